// ===== src/kle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_pkg: shared types and constants of the keyboard line editor
// Scancode map, result kinds, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package kle_pkg;

   localparam int LINE_CAPACITY = 63;
   localparam int SCREEN_ROWS   = 25;
   localparam int SCREEN_COLS   = 80;

   localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
   localparam int FILL_W = 6;
   localparam int ROW_W  = 5;
   localparam int CELL_W = 11;
   localparam int CHAR_W = 7;
   localparam int COL_W  = 7;
   localparam int CODE_W = 8;
   localparam int KIND_W = 2;

   localparam logic [CELL_W-1:0] LAST_CELL  = CELL_W'(SCREEN_ROWS * SCREEN_COLS - 1);
   localparam logic [CELL_W-1:0] CELL_MAX   = '1;
   localparam logic [COL_W-1:0]  PROMPT_RST = COL_W'(2);

   localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
   localparam logic [CHAR_W-1:0] CHAR_BS    = 7'h08;
   localparam logic [CHAR_W-1:0] CHAR_NL    = 7'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

   localparam logic OP_KEY   = 1'b0;
   localparam logic OP_BEGIN = 1'b1;

   typedef enum logic [KIND_W-1:0] {
      KIND_ECHO,
      KIND_ERASE,
      KIND_LINE_CHAR,
      KIND_LINE_END
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_EDIT,
      ST_STREAM,
      ST_LINE_END
   } state_type;

   typedef struct packed {
      logic capture;
      logic begin_line;
      logic enter_start;
      logic edit_out;
      logic stream_out;
      logic line_end;
   } cmd_type;

   typedef struct packed {
      logic op_begin;
      logic key_enter;
      logic key_bs;
      logic key_print;
      logic fill_zero;
      logic fill_full;
      logic stream_more;
      logic out_free;
   } status_type;

   // set-1 make code to ASCII; release codes and unmapped keys give CHAR_NONE
   function automatic logic [CHAR_W-1:0] key_to_ascii(input logic [CODE_W-1:0] code);
      unique case (code)
         8'd2:    return 7'h31;
         8'd3:    return 7'h32;
         8'd4:    return 7'h33;
         8'd5:    return 7'h34;
         8'd6:    return 7'h35;
         8'd7:    return 7'h36;
         8'd8:    return 7'h37;
         8'd9:    return 7'h38;
         8'd10:   return 7'h39;
         8'd11:   return 7'h30;
         8'd12:   return 7'h2D;
         8'd13:   return 7'h3D;
         8'd14:   return CHAR_BS;
         8'd16:   return 7'h71;
         8'd17:   return 7'h77;
         8'd18:   return 7'h65;
         8'd19:   return 7'h72;
         8'd20:   return 7'h74;
         8'd21:   return 7'h79;
         8'd22:   return 7'h75;
         8'd23:   return 7'h69;
         8'd24:   return 7'h6F;
         8'd25:   return 7'h70;
         8'd26:   return 7'h5B;
         8'd27:   return 7'h5D;
         8'd28:   return CHAR_NL;
         8'd30:   return 7'h61;
         8'd31:   return 7'h73;
         8'd32:   return 7'h64;
         8'd33:   return 7'h66;
         8'd34:   return 7'h67;
         8'd35:   return 7'h68;
         8'd36:   return 7'h6A;
         8'd37:   return 7'h6B;
         8'd38:   return 7'h6C;
         8'd39:   return 7'h3B;
         8'd40:   return 7'h27;
         8'd41:   return 7'h60;
         8'd43:   return 7'h5C;
         8'd44:   return 7'h7A;
         8'd45:   return 7'h78;
         8'd46:   return 7'h63;
         8'd47:   return 7'h76;
         8'd48:   return 7'h62;
         8'd49:   return 7'h6E;
         8'd50:   return 7'h6D;
         8'd51:   return 7'h2C;
         8'd52:   return 7'h2E;
         8'd53:   return 7'h2F;
         8'd57:   return CHAR_SPACE;
         default: return CHAR_NONE;
      endcase
   endfunction

endpackage

// ===== src/kle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_ctrl: line editor sequencer
// Takes one beat at a time and steps the datapath through decode, edit
// and line streaming.
// ----------------------------------------------------------------------------
module kle_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  kle_pkg::status_type status,
   output kle_pkg::cmd_type    cmd
);

   kle_pkg::state_type state_ff;
   kle_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kle_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kle_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = kle_pkg::ST_DECODE;
            end
         end
         kle_pkg::ST_DECODE: begin
            priority if (status.op_begin) begin
               state_in = kle_pkg::ST_IDLE;
            end else if (status.key_enter) begin
               state_in = status.fill_zero ? kle_pkg::ST_LINE_END : kle_pkg::ST_STREAM;
            end else if (status.key_bs && !status.fill_zero) begin
               state_in = kle_pkg::ST_EDIT;
            end else if (status.key_print && !status.fill_full) begin
               state_in = kle_pkg::ST_EDIT;
            end else begin
               state_in = kle_pkg::ST_IDLE;
            end
         end
         kle_pkg::ST_EDIT: begin
            if (status.out_free) begin
               state_in = kle_pkg::ST_IDLE;
            end
         end
         kle_pkg::ST_STREAM: begin
            if (status.out_free && !status.stream_more) begin
               state_in = kle_pkg::ST_LINE_END;
            end
         end
         kle_pkg::ST_LINE_END: begin
            if (status.out_free) begin
               state_in = kle_pkg::ST_IDLE;
            end
         end
         default: state_in = kle_pkg::ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         kle_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         kle_pkg::ST_DECODE: begin
            cmd.begin_line  = status.op_begin;
            cmd.enter_start = !status.op_begin && status.key_enter;
         end
         kle_pkg::ST_EDIT: begin
            cmd.edit_out = status.out_free;
         end
         kle_pkg::ST_STREAM: begin
            cmd.stream_out = status.out_free;
         end
         kle_pkg::ST_LINE_END: begin
            cmd.line_end = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== src/kle_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kle_dp: line editor datapath
// Holds the beat, cursor state, the line memory and the result register.
// ----------------------------------------------------------------------------
module kle_dp (
   input  logic                               clock,
   input  logic                               reset,
   input  kle_pkg::cmd_type                   cmd,
   output kle_pkg::status_type                status,
   input  logic                               req_operation,
   input  logic [kle_pkg::CODE_W-1:0]         req_scancode,
   input  logic [kle_pkg::ROW_W-1:0]          req_start_row,
   input  logic                               csr_valid,
   input  logic [kle_pkg::COL_W-1:0]          csr_prompt_column,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output logic [kle_pkg::KIND_W-1:0]         rsp_kind,
   output logic [kle_pkg::CHAR_W-1:0]         rsp_character,
   output logic [kle_pkg::CELL_W-1:0]         rsp_cell_res,
   output logic [kle_pkg::ROW_W-1:0]          rsp_current_row,
   output logic [kle_pkg::FILL_W-1:0]         rsp_line_length,
   output logic                               rsp_scrolled,
   output logic                               rsp_last
);

   // captured beat
   logic                          op_ff;
   logic [kle_pkg::CODE_W-1:0]    code_ff;
   logic [kle_pkg::ROW_W-1:0]     srow_ff;

   // editor state
   logic [kle_pkg::COL_W-1:0]     prompt_ff;
   logic [kle_pkg::ROW_W-1:0]     row_ff,    row_in;
   logic [kle_pkg::CELL_W-1:0]    cursor_ff, cursor_in;
   logic [kle_pkg::FILL_W-1:0]    fill_ff,   fill_in;
   logic [kle_pkg::FILL_W-1:0]    idx_ff,    idx_in;
   logic                          scr_ff,    scr_in;

   // line memory
   logic [kle_pkg::CHAR_W-1:0]    line_mem [kle_pkg::LINE_CAPACITY];
   logic [kle_pkg::CHAR_W-1:0]    rd_data_ff;
   logic                          rd_en;
   logic [kle_pkg::ADDR_W-1:0]    rd_addr;
   logic                          wr_en;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   kle_pkg::kind_type             kind_ff,  kind_in;
   logic [kle_pkg::CHAR_W-1:0]    char_ff,  char_in;
   logic [kle_pkg::CELL_W-1:0]    cell_ff,  cell_in;
   logic [kle_pkg::ROW_W-1:0]     orow_ff,  orow_in;
   logic [kle_pkg::FILL_W-1:0]    len_ff,   len_in;
   logic                          oscr_ff,  oscr_in;
   logic                          last_ff,  last_in;
   logic                          out_load;

   // decode helpers
   logic [kle_pkg::CHAR_W-1:0]    ch;
   logic [kle_pkg::COL_W-1:0]     col_used;
   logic [kle_pkg::ROW_W-1:0]     srow_sat;
   logic [kle_pkg::ROW_W:0]       row_inc;
   logic                          row_wrap;
   logic [kle_pkg::ROW_W-1:0]     row_next_line;
   logic [kle_pkg::ROW_W-1:0]     base_row;
   logic [kle_pkg::CELL_W-1:0]    base_cell;
   logic [kle_pkg::CELL_W-1:0]    cursor_dec, cursor_inc;
   logic [kle_pkg::FILL_W-1:0]    fill_inc, fill_dec, idx_inc;
   logic                          out_free;

   function automatic logic [kle_pkg::CELL_W-1:0] clamp_cell(
      input logic [kle_pkg::CELL_W-1:0] c);
      return (c > kle_pkg::LAST_CELL) ? kle_pkg::LAST_CELL : c;
   endfunction

   assign ch       = kle_pkg::key_to_ascii(code_ff);
   assign col_used = (prompt_ff >= kle_pkg::COL_W'(kle_pkg::SCREEN_COLS))
                   ? kle_pkg::COL_W'(kle_pkg::SCREEN_COLS - 1) : prompt_ff;
   assign srow_sat = (srow_ff >= kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS))
                   ? kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS - 1) : srow_ff;
   assign row_inc       = {1'b0, row_ff} + (kle_pkg::ROW_W+1)'(1);
   assign row_wrap      = row_inc >= (kle_pkg::ROW_W+1)'(kle_pkg::SCREEN_ROWS);
   assign row_next_line = row_wrap ? kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS - 1)
                                   : row_inc[kle_pkg::ROW_W-1:0];
   assign base_row  = cmd.begin_line ? srow_sat : row_ff;
   assign base_cell = kle_pkg::CELL_W'(base_row) * kle_pkg::CELL_W'(kle_pkg::SCREEN_COLS)
                    + kle_pkg::CELL_W'(col_used);
   assign cursor_dec = (cursor_ff == '0) ? '0 : cursor_ff - kle_pkg::CELL_W'(1);
   assign cursor_inc = (cursor_ff == kle_pkg::CELL_MAX) ? kle_pkg::CELL_MAX
                                                        : cursor_ff + kle_pkg::CELL_W'(1);
   assign fill_inc = fill_ff + kle_pkg::FILL_W'(1);
   assign fill_dec = fill_ff - kle_pkg::FILL_W'(1);
   assign idx_inc  = idx_ff + kle_pkg::FILL_W'(1);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      status.op_begin    = (op_ff == kle_pkg::OP_BEGIN);
      status.key_enter   = (op_ff == kle_pkg::OP_KEY) && (ch == kle_pkg::CHAR_NL);
      status.key_bs      = (op_ff == kle_pkg::OP_KEY) && (ch == kle_pkg::CHAR_BS);
      status.key_print   = (op_ff == kle_pkg::OP_KEY) && (ch != kle_pkg::CHAR_NONE)
                         && (ch != kle_pkg::CHAR_NL) && (ch != kle_pkg::CHAR_BS);
      status.fill_zero   = (fill_ff == '0);
      status.fill_full   = (fill_ff >= kle_pkg::FILL_W'(kle_pkg::LINE_CAPACITY));
      status.stream_more = (idx_inc < fill_ff);
      status.out_free    = out_free;
   end

   always_comb begin
      row_in    = row_ff;
      cursor_in = cursor_ff;
      fill_in   = fill_ff;
      idx_in    = idx_ff;
      scr_in    = scr_ff;
      rd_en     = 1'b0;
      rd_addr   = idx_inc[kle_pkg::ADDR_W-1:0];
      wr_en     = 1'b0;
      out_load  = 1'b0;
      kind_in   = kind_ff;
      char_in   = char_ff;
      cell_in   = cell_ff;
      len_in    = len_ff;
      oscr_in   = 1'b0;
      last_in   = 1'b1;

      if (cmd.begin_line) begin
         row_in    = srow_sat;
         cursor_in = base_cell;
         fill_in   = '0;
      end

      if (cmd.enter_start) begin
         row_in  = row_next_line;
         scr_in  = row_wrap;
         idx_in  = '0;
         rd_en   = !status.fill_zero;
         rd_addr = '0;
      end

      if (cmd.edit_out) begin
         out_load = 1'b1;
         if (status.key_bs) begin
            fill_in   = fill_dec;
            cursor_in = cursor_dec;
            kind_in   = kle_pkg::KIND_ERASE;
            char_in   = kle_pkg::CHAR_SPACE;
            cell_in   = clamp_cell(cursor_dec);
            len_in    = fill_dec;
         end else begin
            wr_en     = 1'b1;
            fill_in   = fill_inc;
            cursor_in = cursor_inc;
            kind_in   = kle_pkg::KIND_ECHO;
            char_in   = ch;
            cell_in   = clamp_cell(cursor_ff);
            len_in    = fill_inc;
         end
      end

      if (cmd.stream_out) begin
         out_load = 1'b1;
         kind_in  = kle_pkg::KIND_LINE_CHAR;
         char_in  = rd_data_ff;
         cell_in  = '0;
         len_in   = fill_ff;
         last_in  = 1'b0;
         idx_in   = idx_inc;
         rd_en    = status.stream_more;
      end

      if (cmd.line_end) begin
         out_load  = 1'b1;
         kind_in   = kle_pkg::KIND_LINE_END;
         char_in   = kle_pkg::CHAR_NONE;
         cell_in   = '0;
         len_in    = fill_ff;
         oscr_in   = scr_ff;
         fill_in   = '0;
         cursor_in = base_cell;
      end

      orow_in      = row_ff;
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_ff    <= kle_pkg::PROMPT_RST;
         row_ff       <= '0;
         cursor_ff    <= kle_pkg::CELL_W'(kle_pkg::PROMPT_RST);
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            prompt_ff <= csr_prompt_column;
         end
         row_ff       <= row_in;
         cursor_ff    <= cursor_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and scratch registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         code_ff <= req_scancode;
         srow_ff <= req_start_row;
      end
      idx_ff <= idx_in;
      scr_ff <= scr_in;
      if (out_load) begin
         kind_ff <= kind_in;
         char_ff <= char_in;
         cell_ff <= cell_in;
         orow_ff <= orow_in;
         len_ff  <= len_in;
         oscr_ff <= oscr_in;
         last_ff <= last_in;
      end
   end

   // line memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[fill_ff[kle_pkg::ADDR_W-1:0]] <= ch;
      end
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = kind_ff;
   assign rsp_character   = char_ff;
   assign rsp_cell_res    = cell_ff;
   assign rsp_current_row = orow_ff;
   assign rsp_line_length = len_ff;
   assign rsp_scrolled    = oscr_ff;
   assign rsp_last        = last_ff;

endmodule

// ===== src/keyboard_line_editor_top.sv =====
// Begin-line and ignored keys produce no beat and free the input once
//   DECODE returns to IDLE; echo/erase beats are loaded into the result register from EDIT.
// Throughput: one item at a time; Enter holds the input until the stored
//   line and its line-end beat are out, paced by the single line-memory read
//   port and one result beat per cycle while the output is not stalled.
// Reset: synchronous, active high; row 0, cursor cell 2, empty line, prompt 2.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_line_editor_top: scancode-driven single-line text editor
// Maps set-1 make codes to ASCII, echoes and erases screen cells, and on
// Enter streams the stored line followed by a line-end beat.
// ----------------------------------------------------------------------------
module keyboard_line_editor_top (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_operation,
   input  logic [kle_pkg::CODE_W-1:0]         req_scancode,
   input  logic [kle_pkg::ROW_W-1:0]          req_start_row,
   // prompt column register
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [kle_pkg::COL_W-1:0]          csr_prompt_column,
   // response channel
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [kle_pkg::KIND_W-1:0]         rsp_kind,
   output logic [kle_pkg::CHAR_W-1:0]         rsp_character,
   output logic [kle_pkg::CELL_W-1:0]         rsp_cell_res,
   output logic [kle_pkg::ROW_W-1:0]          rsp_current_row,
   output logic [kle_pkg::FILL_W-1:0]         rsp_line_length,
   output logic                               rsp_scrolled,
   output logic                               rsp_last
);

   kle_pkg::cmd_type    cmd;
   kle_pkg::status_type status;

   // The prompt register is written whenever a beat shows up, with no hold-off;
   // writes must only happen while the editor is idle, which it does not enforce.
   assign csr_ready = 1'b1;

   // Sequencer: IDLE takes a beat, DECODE classifies it, then EDIT (echo or
   // erase), or for Enter STREAM (if the line is not empty) and LINE_END.
   // Every result goes through the output register, so the controller only
   // waits when that register is still full and stalled.
   kle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Datapath: beat capture, scancode map, row/cursor/fill state, 63-entry
   // line memory with registered read (next character is prefetched while
   // the current one is offered), and the result register.
   kle_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_scancode      (req_scancode),
      .req_start_row     (req_start_row),
      .csr_valid         (csr_valid),
      .csr_prompt_column (csr_prompt_column),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_character     (rsp_character),
      .rsp_cell_res      (rsp_cell_res),
      .rsp_current_row   (rsp_current_row),
      .rsp_line_length   (rsp_line_length),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_last          (rsp_last)
   );

   // one item in flight: an accepted beat closes the input next cycle
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input accepted while previous item still in work");

   // streamed line characters never close the item or flag a scroll
   a_line_char_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == kle_pkg::KIND_LINE_CHAR) |-> !rsp_last && !rsp_scrolled)
      else $error("line character beat with last or scrolled set");

   // scroll only on a line end, with the row pinned to the bottom
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |->
         (rsp_kind == kle_pkg::KIND_LINE_END) &&
         (rsp_current_row == kle_pkg::ROW_W'(kle_pkg::SCREEN_ROWS - 1)))
      else $error("scroll flagged off the last row or not on line end");

   // erase writes a blank and is the only beat of its item
   a_erase_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == kle_pkg::KIND_ERASE) |->
         (rsp_character == kle_pkg::CHAR_SPACE) && rsp_last)
      else $error("erase beat without blank character or last");

endmodule

// ===== tb/keyboard_line_editor_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyboard_line_editor_top_test: self-checking bench for the line editor
// Drives scancode and begin-line beats with random gaps, stalls the result
// side at random, and checks every result beat against a shadow of the
// editor state (row, cursor, fill count, stored line, prompt column).
// ----------------------------------------------------------------------------
module keyboard_line_editor_top_test;

   // set-1 make codes used by name in the stimulus
   localparam logic [kle_pkg::CODE_W-1:0] SC_NONE      = 8'd0;   // unmapped
   localparam logic [kle_pkg::CODE_W-1:0] SC_ONE       = 8'd2;
   localparam logic [kle_pkg::CODE_W-1:0] SC_BACKSPACE = 8'd14;
   localparam logic [kle_pkg::CODE_W-1:0] SC_Q         = 8'd16;
   localparam logic [kle_pkg::CODE_W-1:0] SC_ENTER     = 8'd28;
   localparam logic [kle_pkg::CODE_W-1:0] SC_A         = 8'd30;
   localparam logic [kle_pkg::CODE_W-1:0] SC_BACKTICK  = 8'd41;
   localparam logic [kle_pkg::CODE_W-1:0] SC_LSHIFT    = 8'd42;  // in range, no char
   localparam logic [kle_pkg::CODE_W-1:0] SC_SLASH     = 8'd53;
   localparam logic [kle_pkg::CODE_W-1:0] SC_SPACE     = 8'd57;  // highest mapped code
   localparam logic [kle_pkg::CODE_W-1:0] SC_CAPS      = 8'd58;  // first code past the map
   localparam logic [kle_pkg::CODE_W-1:0] SC_RELEASE   = 8'h80;

   localparam int SETTLE_CYCLES = 12;   // covers the free-up of beatless items
   localparam int LONG_HOLD     = 400;  // receiver back-pressure stretch

   typedef struct {
      kle_pkg::kind_type          kind;
      logic [kle_pkg::CHAR_W-1:0] character;
      logic [kle_pkg::CELL_W-1:0] cell_idx;
      logic [kle_pkg::ROW_W-1:0]  row_now;
      logic [kle_pkg::FILL_W-1:0] length;
      logic                       scrolled;
      logic                       last;
   } editor_beat_type;

   // Shadow of the editor: tracks the line and cursor, queues the beats that
   // each accepted item must produce, and checks beats in arrival order.
   class editor_tracker_type;
      logic [kle_pkg::CHAR_W-1:0] keymap [58];
      logic [kle_pkg::CHAR_W-1:0] line_chars [kle_pkg::LINE_CAPACITY];
      int                         prompt_column;
      int                         row;
      int                         cursor;
      int                         fill;
      int                         fail_count;
      editor_beat_type            due_beats [$];

      function new();
         keymap = '{7'h00, 7'h00, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
                    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, kle_pkg::CHAR_BS, 7'h00,
                    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
                    7'h6F, 7'h70, 7'h5B, 7'h5D, kle_pkg::CHAR_NL, 7'h00, 7'h61, 7'h73,
                    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
                    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
                    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h00,
                    7'h00, kle_pkg::CHAR_SPACE};
         prompt_column = int'(kle_pkg::PROMPT_RST);
         row           = 0;
         cursor        = int'(kle_pkg::PROMPT_RST);
         fill          = 0;
         fail_count    = 0;
      endfunction

      // prompt columns past the right edge pin to the last column
      function int home_column();
         return (prompt_column >= kle_pkg::SCREEN_COLS) ? kle_pkg::SCREEN_COLS - 1
                                                        : prompt_column;
      endfunction

      function void queue_beat(kle_pkg::kind_type k, logic [kle_pkg::CHAR_W-1:0] ch,
                               int cell_at, int len, logic scr, logic lst);
         editor_beat_type b;
         b.kind      = k;
         b.character = ch;
         b.cell_idx  = kle_pkg::CELL_W'(cell_at);
         b.row_now   = kle_pkg::ROW_W'(row);
         b.length    = kle_pkg::FILL_W'(len);
         b.scrolled  = scr;
         b.last      = lst;
         due_beats.push_back(b);
      endfunction

      function void apply_item(logic op, logic [kle_pkg::CODE_W-1:0] code,
                               logic [kle_pkg::ROW_W-1:0] start_row);
         logic [kle_pkg::CHAR_W-1:0] ch;
         int                         len;
         logic                       scr;
         if (op == kle_pkg::OP_BEGIN) begin
            row    = (start_row >= kle_pkg::SCREEN_ROWS) ? kle_pkg::SCREEN_ROWS - 1
                                                         : start_row;
            cursor = row * kle_pkg::SCREEN_COLS + home_column();
            fill   = 0;
            return;
         end
         if (code[7] || code >= 58)
            return;
         ch = keymap[code[5:0]];
         if (ch == kle_pkg::CHAR_NONE)
            return;
         if (ch == kle_pkg::CHAR_NL) begin
            len = fill;
            scr = 1'b0;
            row = row + 1;
            if (row >= kle_pkg::SCREEN_ROWS) begin
               scr = 1'b1;
               row = kle_pkg::SCREEN_ROWS - 1;
            end
            for (int k = 0; k < len; k++)
               queue_beat(kle_pkg::KIND_LINE_CHAR, line_chars[kle_pkg::ADDR_W'(k)], 0, len,
                          1'b0, 1'b0);
            queue_beat(kle_pkg::KIND_LINE_END, kle_pkg::CHAR_NONE, 0, len, scr, 1'b1);
            fill   = 0;
            cursor = row * kle_pkg::SCREEN_COLS + home_column();
         end else if (ch == kle_pkg::CHAR_BS) begin
            if (fill == 0)
               return;
            fill--;
            if (cursor > 0)
               cursor--;
            queue_beat(kle_pkg::KIND_ERASE, kle_pkg::CHAR_SPACE,
                       (cursor > kle_pkg::LAST_CELL) ? kle_pkg::LAST_CELL : cursor,
                       fill, 1'b0, 1'b1);
         end else begin
            if (fill >= kle_pkg::LINE_CAPACITY)
               return;  // line full: key dropped
            line_chars[kle_pkg::ADDR_W'(fill)] = ch;
            fill++;
            queue_beat(kle_pkg::KIND_ECHO, ch,
                       (cursor > kle_pkg::LAST_CELL) ? kle_pkg::LAST_CELL : cursor,
                       fill, 1'b0, 1'b1);
            if (cursor < kle_pkg::CELL_MAX)
               cursor++;
         end
      endfunction

      function void compare_field(string field, logic [kle_pkg::CELL_W-1:0] want,
                                  logic [kle_pkg::CELL_W-1:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            fail_count++;
         end
      endfunction

      function void check_beat(logic [kle_pkg::KIND_W-1:0] kind,
                               logic [kle_pkg::CHAR_W-1:0] ch,
                               logic [kle_pkg::CELL_W-1:0] cell_at,
                               logic [kle_pkg::ROW_W-1:0]  row_at,
                               logic [kle_pkg::FILL_W-1:0] len, logic scr, logic lst);
         editor_beat_type b;
         if (due_beats.size() == 0) begin
            $error("result beat with nothing pending (kind %0d char %0h)", kind, ch);
            fail_count++;
            return;
         end
         b = due_beats.pop_front();
         compare_field("kind", kle_pkg::CELL_W'(b.kind), kle_pkg::CELL_W'(kind));
         compare_field("character", kle_pkg::CELL_W'(b.character), kle_pkg::CELL_W'(ch));
         compare_field("cell_res", b.cell_idx, cell_at);
         compare_field("current_row", kle_pkg::CELL_W'(b.row_now), kle_pkg::CELL_W'(row_at));
         compare_field("line_length", kle_pkg::CELL_W'(b.length), kle_pkg::CELL_W'(len));
         compare_field("scrolled", kle_pkg::CELL_W'(b.scrolled), kle_pkg::CELL_W'(scr));
         compare_field("last", kle_pkg::CELL_W'(b.last), kle_pkg::CELL_W'(lst));
      endfunction
   endclass

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic                         req_operation;
   logic [kle_pkg::CODE_W-1:0]   req_scancode;
   logic [kle_pkg::ROW_W-1:0]    req_start_row;
   logic                         csr_valid;
   logic                         csr_ready;
   logic [kle_pkg::COL_W-1:0]    csr_prompt_column;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic [kle_pkg::KIND_W-1:0]   rsp_kind;
   logic [kle_pkg::CHAR_W-1:0]   rsp_character;
   logic [kle_pkg::CELL_W-1:0]   rsp_cell_res;
   logic [kle_pkg::ROW_W-1:0]    rsp_current_row;
   logic [kle_pkg::FILL_W-1:0]   rsp_line_length;
   logic                         rsp_scrolled;
   logic                         rsp_last;

   editor_tracker_type tracker = new();

   // steady: both sides run without gaps or stalls
   bit steady     = 1'b0;
   // set by the stimulus, consumed by the receiver as one long stall
   int hold_cycles = 0;

   keyboard_line_editor_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_scancode      (req_scancode),
      .req_start_row     (req_start_row),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_prompt_column (csr_prompt_column),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_character     (rsp_character),
      .rsp_cell_res      (rsp_cell_res),
      .rsp_current_row   (rsp_current_row),
      .rsp_line_length   (rsp_line_length),
      .rsp_scrolled      (rsp_scrolled),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop. The slowest legal run (every key an Enter on a full line,
   // every beat stalled for the longest pause) stays well under a fifth of this.
   initial begin
      #(20_000_000);
      $display("keyboard_line_editor_top: mismatch");
      $finish;
   end

   // Any mapped code that lands in the line: not backspace, enter or unmapped.
   function automatic logic [kle_pkg::CODE_W-1:0] printable_code();
      logic [kle_pkg::CODE_W-1:0] code;
      do
         code = kle_pkg::CODE_W'($urandom_range(2, 57));
      while (tracker.keymap[code[5:0]] == kle_pkg::CHAR_NONE ||
             tracker.keymap[code[5:0]] == kle_pkg::CHAR_BS ||
             tracker.keymap[code[5:0]] == kle_pkg::CHAR_NL);
      return code;
   endfunction

   // One input beat. Valid stays high across back-to-back beats; it only
   // drops when a gap is drawn, so it never sees two assignments in a step.
   // The tracker is updated at the accepting edge.
   task automatic send_item(logic op, logic [kle_pkg::CODE_W-1:0] code,
                            logic [kle_pkg::ROW_W-1:0] start_row);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         req_valid <= 1'b1;
      end else if (!req_valid) begin
         req_valid <= 1'b1;
      end
      req_operation <= op;
      req_scancode  <= code;
      req_start_row <= start_row;
      do @(posedge clock); while (req_stall);
      tracker.apply_item(op, code, start_row);
   endtask

   // start_row is don't-care for keys, so it gets random bits there
   task automatic send_key(logic [kle_pkg::CODE_W-1:0] code);
      send_item(kle_pkg::OP_KEY, code, kle_pkg::ROW_W'($urandom_range(0, 31)));
   endtask

   task automatic send_begin(logic [kle_pkg::ROW_W-1:0] start_row);
      send_item(kle_pkg::OP_BEGIN, kle_pkg::CODE_W'($urandom_range(0, 255)), start_row);
   endtask

   // Mostly well-formed typing (chars, edits, enters, new lines), the rest
   // is raw noise over both operations and the whole scancode byte.
   task automatic send_random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 58)
         send_key(printable_code());
      else if (pick < 68)
         send_key(SC_BACKSPACE);
      else if (pick < 76)
         send_key(SC_ENTER);
      else if (pick < 81)
         send_begin(kle_pkg::ROW_W'($urandom_range(0, 31)));
      else
         send_item(1'($urandom_range(0, 1)), kle_pkg::CODE_W'($urandom_range(0, 255)),
                   kle_pkg::ROW_W'($urandom_range(0, 31)));
   endtask

   // Stop offering, wait for every pending beat, then let beatless items
   // that may still be in flight finish before anything else happens.
   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.due_beats.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Only called on an idle block (after drain).
   task automatic write_prompt(logic [kle_pkg::COL_W-1:0] column);
      csr_valid         <= 1'b1;
      csr_prompt_column <= column;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      tracker.prompt_column = int'(column);
   endtask

   // Result side: random stall before each beat, plus the one long hold
   // that backs the block up into its input.
   initial begin : result_sink
      int pause;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         pause = steady ? 0 : $urandom_range(0, 9);
         if (hold_cycles > 0) begin
            pause       = hold_cycles;
            hold_cycles = 0;
         end
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         tracker.check_beat(rsp_kind, rsp_character, rsp_cell_res, rsp_current_row,
                            rsp_line_length, rsp_scrolled, rsp_last);
      end
   end

   initial begin : stimulus
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= kle_pkg::OP_KEY;
      req_scancode      <= '0;
      req_start_row     <= '0;
      csr_valid         <= 1'b0;
      csr_prompt_column <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, reset prompt column ---
      send_begin(0);
      send_key(SC_A);                     // echo at the reset cursor
      send_key(SC_ONE);
      send_key(SC_RELEASE | SC_A);        // release: ignored
      send_key(SC_CAPS);                  // past the map: ignored
      send_key(8'hFF);
      send_key(SC_NONE);                  // unmapped codes
      send_key(SC_LSHIFT);
      send_key(SC_RELEASE);
      send_key(SC_SPACE);
      send_key(SC_BACKSPACE);             // erase the space
      send_key(SC_SLASH);
      send_key(SC_ENTER);                 // stream three chars, then line end
      send_key(SC_ENTER);                 // empty line: line end only
      send_key(SC_BACKSPACE);             // nothing to erase
      send_begin(31);                     // row saturates to the last row
      send_key(SC_Q);
      send_key(SC_ENTER);                 // scrolls
      send_begin(23);
      send_key(SC_BACKTICK);
      send_key(SC_ENTER);                 // reaches the last row, no scroll
      send_key(SC_ENTER);                 // scrolls on an empty line
      drain();

      // --- prompt at column 0, random typing; long receiver hold midway ---
      write_prompt(7'd0);
      for (int n = 0; n < 120; n++) begin
         if (n == 40)
            hold_cycles = LONG_HOLD;
         send_random_item();
      end
      drain();

      // --- prompt past the right edge: overfull lines at the screen end ---
      write_prompt(7'd127);
      send_begin(24);
      repeat (70) send_key(printable_code());   // last 7 dropped, cursor saturates
      repeat (3) send_key(SC_BACKSPACE);
      repeat (3) send_key(printable_code());
      send_key(SC_ENTER);                       // full 63-char stream, scrolls
      send_begin(31);
      repeat (66) send_key(printable_code());
      send_key(SC_ENTER);
      drain();

      // --- last column, no gaps and no stalls ---
      write_prompt(7'd79);
      steady = 1'b1;
      repeat (60) send_random_item();
      drain();
      steady = 1'b0;

      // --- first column past the edge ---
      write_prompt(7'd80);
      repeat (40) send_random_item();
      drain();

      // --- random prompt column ---
      write_prompt(kle_pkg::COL_W'($urandom_range(0, 127)));
      repeat (32) send_random_item();
      drain();

      if (tracker.fail_count == 0 && tracker.due_beats.size() == 0)
         $display("keyboard_line_editor_top: match");
      else
         $display("keyboard_line_editor_top: mismatch");
      $finish;
   end

endmodule
